FILE: rtl/fkpc_pkg.sv
package fkpc_pkg;

    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int EVENT_W    = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DEBOUNCE        = 2'd0,
        CFG_LONG_PRESS      = 2'd1,
        CFG_REPEAT_START    = 2'd2,
        CFG_REPEAT_INTERVAL = 2'd3
    } t_cfg_addr;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE        = 16'd10;
    localparam logic [CFG_W-1:0] RST_LONG_PRESS      = 16'd100;
    localparam logic [CFG_W-1:0] RST_REPEAT_START    = 16'd100;
    localparam logic [CFG_W-1:0] RST_REPEAT_INTERVAL = 16'd20;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE       = 4'd0,
        EV_ONE_SHORT  = 4'd1,
        EV_ONE_LONG   = 4'd2,
        EV_TWO_SHORT  = 4'd3,
        EV_TWO_LONG   = 4'd4,
        EV_THREE_PRESS  = 4'd5,
        EV_THREE_REPEAT = 4'd6,
        EV_FOUR_PRESS   = 4'd7,
        EV_FOUR_REPEAT  = 4'd8
    } t_key_event;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] long_press;
        logic [CFG_W-1:0] repeat_start;
        logic [CFG_W-1:0] repeat_interval;
    } t_cfg;

    typedef struct packed {
        logic short_hit;
        logic long_hit;
    } t_release_evt;

    typedef struct packed {
        logic press_hit;
        logic repeat_hit;
    } t_repeat_evt;

endpackage

FILE: rtl/fkpc_release_key.sv
module fkpc_release_key #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_level,
    input  fkpc_pkg::t_cfg        i_cfg,
    output fkpc_pkg::t_release_evt o_evt
);
    import fkpc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    logic [COUNT_WIDTH-1:0] r_hold, n_hold, hold_inc;
    logic                   r_locked, n_locked;
    logic                   r_short, n_short;
    logic                   r_long, n_long;
    logic [CMP_W-1:0]       inc_ext, db_ext, lp_ext;

    assign hold_inc = (r_hold == {COUNT_WIDTH{1'b1}}) ? r_hold : r_hold + 1'b1;
    assign inc_ext  = CMP_W'(hold_inc);
    assign db_ext   = CMP_W'(i_cfg.debounce);
    assign lp_ext   = CMP_W'(i_cfg.long_press);

    // events only fire on release
    assign o_evt.short_hit = i_level && r_short;
    assign o_evt.long_hit  = i_level && r_long;

    always_comb begin
        n_hold   = r_hold;
        n_locked = r_locked;
        n_short  = r_short;
        n_long   = r_long;
        priority if (i_level) begin
            n_locked = 1'b0;
            n_hold   = '0;
            n_short  = 1'b0;
            n_long   = 1'b0;
        end else if (!r_locked) begin
            n_hold = hold_inc;
            if (inc_ext > db_ext) begin
                n_hold   = '0;
                n_short  = 1'b1;
                n_long   = 1'b0;
                n_locked = 1'b1;
            end
        end else begin
            n_hold = hold_inc;
            if (inc_ext > lp_ext) begin
                n_short = 1'b0;
                n_long  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= '0;
            r_locked <= 1'b0;
            r_short  <= 1'b0;
            r_long   <= 1'b0;
        end else if (i_en) begin
            r_hold   <= n_hold;
            r_locked <= n_locked;
            r_short  <= n_short;
            r_long   <= n_long;
        end
    end

endmodule

FILE: rtl/fkpc_repeat_key.sv
module fkpc_repeat_key #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_level,
    input  fkpc_pkg::t_cfg       i_cfg,
    output fkpc_pkg::t_repeat_evt o_evt
);
    import fkpc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    logic [COUNT_WIDTH-1:0] r_hold, n_hold, hold_inc;
    logic [COUNT_WIDTH-1:0] r_gap, n_gap, gap_inc;
    logic                   r_locked, n_locked;
    logic [CMP_W-1:0]       hold_ext, inc_ext, gap_ext;
    logic                   press_hit, repeat_hit;

    assign hold_inc = (r_hold == {COUNT_WIDTH{1'b1}}) ? r_hold : r_hold + 1'b1;
    assign gap_inc  = (r_gap == {COUNT_WIDTH{1'b1}}) ? r_gap : r_gap + 1'b1;
    assign hold_ext = CMP_W'(r_hold);
    assign inc_ext  = CMP_W'(hold_inc);
    assign gap_ext  = CMP_W'(gap_inc);

    always_comb begin
        n_hold     = r_hold;
        n_gap      = r_gap;
        n_locked   = r_locked;
        press_hit  = 1'b0;
        repeat_hit = 1'b0;
        // gap counter survives a release
        priority if (i_level) begin
            n_locked = 1'b0;
            n_hold   = '0;
        end else if (!r_locked) begin
            n_hold = hold_inc;
            if (inc_ext > CMP_W'(i_cfg.debounce)) begin
                n_hold    = '0;
                n_locked  = 1'b1;
                press_hit = 1'b1;
            end
        end else if (hold_ext < CMP_W'(i_cfg.repeat_start)) begin
            n_hold = hold_inc;
        end else begin
            n_gap = gap_inc;
            if (gap_ext > CMP_W'(i_cfg.repeat_interval)) begin
                n_gap      = '0;
                repeat_hit = 1'b1;
            end
        end
    end

    assign o_evt.press_hit  = press_hit;
    assign o_evt.repeat_hit = repeat_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= '0;
            r_gap    <= '0;
            r_locked <= 1'b0;
        end else if (i_en) begin
            r_hold   <= n_hold;
            r_gap    <= n_gap;
            r_locked <= n_locked;
        end
    end

endmodule

FILE: rtl/four_key_press_classifier_core.sv
// four-key scan classifier: debounce, short/long press and auto-repeat
//
// input channel: i_in_valid / o_in_ready with four active-low key levels,
// one transaction per scan tick. output channel: o_out_valid / i_out_ready
// with one 4-bit event code per tick (0 when nothing happened).
// keys one and two report short or long on release; keys three and four
// report a press once debounced, then repeat events while held.
// configuration: i_cfg_we, i_cfg_addr, i_cfg_wdata, written while idle.
//
// the event of a tick lands in the output register in the cycle after the
// input transaction. throughput: one tick per cycle while the receiver keeps
// up; the key state updates and the compares are combinational between the
// input and the output register, and o_in_ready stays high whenever the output
// register is empty or being emptied in the same cycle.
// stall: while the receiver holds i_out_ready low with a result waiting,
// o_in_ready drops and the key state is frozen.
// reset: counters, lock and pending flags clear, thresholds return to
// 10 / 100 / 100 / 20 ticks, the output register empties.
module four_key_press_classifier_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fkpc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [fkpc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_key_one_level,
    input  logic                            i_key_two_level,
    input  logic                            i_key_three_level,
    input  logic                            i_key_four_level,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [fkpc_pkg::EVENT_W-1:0]    o_key_event
);
    import fkpc_pkg::*;

    t_cfg           r_cfg;
    logic           r_out_valid;
    t_key_event     r_event, n_event;
    logic           accept;
    t_release_evt   evt_one, evt_two;
    t_repeat_evt    evt_three, evt_four;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce        <= RST_DEBOUNCE;
            r_cfg.long_press      <= RST_LONG_PRESS;
            r_cfg.repeat_start    <= RST_REPEAT_START;
            r_cfg.repeat_interval <= RST_REPEAT_INTERVAL;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_DEBOUNCE:        r_cfg.debounce        <= i_cfg_wdata;
                CFG_LONG_PRESS:      r_cfg.long_press      <= i_cfg_wdata;
                CFG_REPEAT_START:    r_cfg.repeat_start    <= i_cfg_wdata;
                CFG_REPEAT_INTERVAL: r_cfg.repeat_interval <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    fkpc_release_key #(.COUNT_WIDTH(COUNT_WIDTH)) u_key_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_level (i_key_one_level),
        .i_cfg   (r_cfg),
        .o_evt   (evt_one)
    );

    fkpc_release_key #(.COUNT_WIDTH(COUNT_WIDTH)) u_key_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_level (i_key_two_level),
        .i_cfg   (r_cfg),
        .o_evt   (evt_two)
    );

    fkpc_repeat_key #(.COUNT_WIDTH(COUNT_WIDTH)) u_key_three (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_level (i_key_three_level),
        .i_cfg   (r_cfg),
        .o_evt   (evt_three)
    );

    fkpc_repeat_key #(.COUNT_WIDTH(COUNT_WIDTH)) u_key_four (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_level (i_key_four_level),
        .i_cfg   (r_cfg),
        .o_evt   (evt_four)
    );

    // higher-numbered key wins
    always_comb begin
        priority if (evt_four.repeat_hit) begin
            n_event = EV_FOUR_REPEAT;
        end else if (evt_four.press_hit) begin
            n_event = EV_FOUR_PRESS;
        end else if (evt_three.repeat_hit) begin
            n_event = EV_THREE_REPEAT;
        end else if (evt_three.press_hit) begin
            n_event = EV_THREE_PRESS;
        end else if (evt_two.long_hit) begin
            n_event = EV_TWO_LONG;
        end else if (evt_two.short_hit) begin
            n_event = EV_TWO_SHORT;
        end else if (evt_one.long_hit) begin
            n_event = EV_ONE_LONG;
        end else if (evt_one.short_hit) begin
            n_event = EV_ONE_SHORT;
        end else begin
            n_event = EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_event <= n_event;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_event = r_event;

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while result is stalled");

    a_accept_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted tick produced no result");

    a_reset_empties_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_event_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_key_event <= EV_FOUR_REPEAT))
        else $error("event code out of range");

endmodule

FILE: tb/four_key_press_classifier_core_test.sv
`timescale 1ns / 1ps

module four_key_press_classifier_core_test;
    import fkpc_pkg::*;

    localparam int CNT_W     = 16;
    localparam int CYCLE_CAP = 1000000;
    localparam int MAX_SHOWN = 10;
    localparam int HOLDOFF   = 300;
    localparam int N_ROWS    = 29;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic             is_cfg;
        t_cfg_addr        addr;
        logic [CFG_W-1:0] data;
        logic [3:0]       keys;
        logic             chk;
        t_key_event       ev;
    } t_scan_row;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    t_cfg_addr          cfg_addr  = CFG_DEBOUNCE;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [3:0]         key_lv    = 4'b1111;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [EVENT_W-1:0] key_event;

    // typed expectation travelling with the transaction on offer
    logic               row_chk   = 1'b0;
    t_key_event         row_ev    = EV_NONE;

    // predictor state
    t_cfg thr;
    t_cnt hold_cnt [4];
    t_cnt gap_cnt [2];
    logic locked [4];
    logic short_pend [2];
    logic long_pend [2];

    t_key_event event_q [$];

    int errors        = 0;
    int cycles        = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int holdoff_asked = 0;
    int holdoff_done  = 0;
    int holdoff_left  = 0;
    int cur_deb       = 10;
    int cur_span      = 50;
    logic [3:0] cur_lv = 4'b1111;
    int run_left [4] = '{0, 0, 0, 0};

    // bit 0 is key one, 1 released, 0 pressed
    t_scan_row scan_tab [N_ROWS] = '{
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1111, 1'b1, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b0000, 1'b1, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1111, 1'b1, EV_NONE},
        '{1'b1, CFG_DEBOUNCE,        16'd0,     4'b1111, 1'b0, EV_NONE},
        '{1'b1, CFG_LONG_PRESS,      16'd1,     4'b1111, 1'b0, EV_NONE},
        '{1'b1, CFG_REPEAT_START,    16'd0,     4'b1111, 1'b0, EV_NONE},
        '{1'b1, CFG_REPEAT_INTERVAL, 16'd0,     4'b1111, 1'b0, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1110, 1'b0, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1111, 1'b1, EV_ONE_SHORT},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1110, 1'b0, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1110, 1'b0, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1110, 1'b0, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1111, 1'b1, EV_ONE_LONG},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1101, 1'b0, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1111, 1'b1, EV_TWO_SHORT},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1011, 1'b1, EV_THREE_PRESS},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1011, 1'b0, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1111, 1'b0, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b0111, 1'b1, EV_FOUR_PRESS},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b0111, 1'b0, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b0000, 1'b0, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1111, 1'b0, EV_NONE},
        '{1'b1, CFG_DEBOUNCE,        16'hffff,  4'b1111, 1'b0, EV_NONE},
        '{1'b1, CFG_LONG_PRESS,      16'hffff,  4'b1111, 1'b0, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b0000, 1'b1, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1111, 1'b1, EV_NONE},
        '{1'b1, CFG_REPEAT_START,    16'hffff,  4'b1111, 1'b0, EV_NONE},
        '{1'b1, CFG_REPEAT_INTERVAL, 16'hffff,  4'b1111, 1'b0, EV_NONE},
        '{1'b0, CFG_DEBOUNCE,        16'd0,     4'b1111, 1'b1, EV_NONE}
    };

    four_key_press_classifier_core #(
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_addr        (cfg_addr),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_key_one_level   (key_lv[0]),
        .i_key_two_level   (key_lv[1]),
        .i_key_three_level (key_lv[2]),
        .i_key_four_level  (key_lv[3]),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_key_event       (key_event)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic t_cnt sat_up(input t_cnt v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void clear_keys();
        int k;
        thr.debounce        = RST_DEBOUNCE;
        thr.long_press      = RST_LONG_PRESS;
        thr.repeat_start    = RST_REPEAT_START;
        thr.repeat_interval = RST_REPEAT_INTERVAL;
        for (k = 0; k < 4; k++) begin
            hold_cnt[k] = '0;
            locked[k]   = 1'b0;
        end
        for (k = 0; k < 2; k++) begin
            gap_cnt[k]    = '0;
            short_pend[k] = 1'b0;
            long_pend[k]  = 1'b0;
        end
    endfunction

    // one scan tick; later keys overwrite the event of earlier ones
    function automatic t_key_event classify_scan(input logic [3:0] lv);
        t_key_event ev;
        int k;
        int r;
        ev = EV_NONE;
        for (k = 0; k < 2; k++) begin
            if (lv[k]) begin
                locked[k]   = 1'b0;
                hold_cnt[k] = '0;
                if (short_pend[k]) begin
                    short_pend[k] = 1'b0;
                    ev = (k == 0) ? EV_ONE_SHORT : EV_TWO_SHORT;
                end
                if (long_pend[k]) begin
                    long_pend[k] = 1'b0;
                    ev = (k == 0) ? EV_ONE_LONG : EV_TWO_LONG;
                end
            end else if (!locked[k]) begin
                hold_cnt[k] = sat_up(hold_cnt[k]);
                if (hold_cnt[k] > thr.debounce) begin
                    hold_cnt[k]   = '0;
                    short_pend[k] = 1'b1;
                    long_pend[k]  = 1'b0;
                    locked[k]     = 1'b1;
                end
            end else begin
                hold_cnt[k] = sat_up(hold_cnt[k]);
                if (hold_cnt[k] > thr.long_press) begin
                    short_pend[k] = 1'b0;
                    long_pend[k]  = 1'b1;
                end
            end
        end
        for (r = 0; r < 2; r++) begin
            k = r + 2;
            if (lv[k]) begin
                locked[k]   = 1'b0;
                hold_cnt[k] = '0;
            end else if (!locked[k]) begin
                hold_cnt[k] = sat_up(hold_cnt[k]);
                if (hold_cnt[k] > thr.debounce) begin
                    hold_cnt[k] = '0;
                    locked[k]   = 1'b1;
                    ev = (r == 0) ? EV_THREE_PRESS : EV_FOUR_PRESS;
                end
            end else if (hold_cnt[k] < thr.repeat_start) begin
                hold_cnt[k] = sat_up(hold_cnt[k]);
            end else begin
                gap_cnt[r] = sat_up(gap_cnt[r]);
                if (gap_cnt[r] > thr.repeat_interval) begin
                    gap_cnt[r] = '0;
                    ev = (r == 0) ? EV_THREE_REPEAT : EV_FOUR_REPEAT;
                end
            end
        end
        return ev;
    endfunction

    function automatic void flag(input string msg);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("%s", msg);
    endfunction

    always @(posedge clk) begin : scoreboard
        t_key_event want;
        if (!rst_n) begin
            clear_keys();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_DEBOUNCE:        thr.debounce        = cfg_wdata;
                    CFG_LONG_PRESS:      thr.long_press      = cfg_wdata;
                    CFG_REPEAT_START:    thr.repeat_start    = cfg_wdata;
                    CFG_REPEAT_INTERVAL: thr.repeat_interval = cfg_wdata;
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                want = classify_scan(key_lv);
                if (row_chk)
                    want = row_ev;
                event_q.push_back(want);
            end
            if (out_valid && out_ready) begin
                if (event_q.size() == 0) begin
                    flag($sformatf("unexpected event %0d at cycle %0d", key_event, cycles));
                end else begin
                    want = event_q.pop_front();
                    if (key_event !== want)
                        flag($sformatf("key_event mismatch at cycle %0d: expected %0d, got %0d",
                                       cycles, want, key_event));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver, with an occasional long hold-off
    always @(posedge clk) begin
        if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            out_ready <= 1'b0;
        end else if (holdoff_done < holdoff_asked) begin
            holdoff_done = holdoff_done + 1;
            holdoff_left = HOLDOFF;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic offer_scan(input logic [3:0] lv, input logic chk, input t_key_event ev);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key_lv   <= lv;
        row_chk  <= chk;
        row_ev   <= ev;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (event_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_addr a, input logic [CFG_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input int d, input int l, input int s, input int iv);
        int reach;
        write_reg(CFG_DEBOUNCE, CFG_W'(d));
        write_reg(CFG_LONG_PRESS, CFG_W'(l));
        write_reg(CFG_REPEAT_START, CFG_W'(s));
        write_reg(CFG_REPEAT_INTERVAL, CFG_W'(iv));
        reach    = d + ((l > s) ? l : s) + 4 * iv + 8;
        cur_deb  = (d > 40) ? 40 : d;
        cur_span = (reach > 300) ? 300 : reach;
    endtask

    function automatic int pick_run(input logic pressed);
        if (!pressed)
            return ($urandom_range(4) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
        if ($urandom_range(9) < 3)
            return $urandom_range(1, cur_deb + 1);
        return $urandom_range(1, cur_span);
    endfunction

    // held and released runs per key, with single-tick glitches as noise
    task automatic random_phase(input int n_items, input int stall_at, input int pause_at);
        logic [3:0] lv;
        int i;
        int k;
        int g;
        for (i = 0; i < n_items; i++) begin
            for (k = 0; k < 4; k++) begin
                if (run_left[k] <= 0) begin
                    cur_lv[k]   = ~cur_lv[k];
                    run_left[k] = pick_run(!cur_lv[k]);
                end
                run_left[k]--;
            end
            lv = cur_lv;
            if ($urandom_range(99) < 6) begin
                g     = $urandom_range(3);
                lv[g] = ~lv[g];
            end
            if (i == stall_at)
                holdoff_asked++;
            if (i == pause_at)
                drain();
            offer_scan(lv, 1'b0, EV_NONE);
        end
    endtask

    initial begin
        int j;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 35;
        rx_idle_pct = 47;
        for (j = 0; j < N_ROWS; j++) begin
            if (scan_tab[j].is_cfg)
                write_reg(scan_tab[j].addr, scan_tab[j].data);
            else
                offer_scan(scan_tab[j].keys, scan_tab[j].chk, scan_tab[j].ev);
        end

        configure($urandom_range(4), $urandom_range(12), $urandom_range(10), $urandom_range(5));
        random_phase(300, 120, -1);
        configure(0, 0, 0, 0);
        random_phase(300, -1, -1);

        tx_idle_pct = 47;
        rx_idle_pct = 35;
        configure($urandom_range(4), $urandom_range(12), $urandom_range(10), $urandom_range(5));
        random_phase(300, -1, 150);
        configure(2, 65535, 65535, 65535);
        random_phase(300, -1, -1);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure($urandom_range(10), $urandom_range(40), $urandom_range(40),
                  $urandom_range(15));
        random_phase(300, 100, -1);
        configure($urandom_range(4), $urandom_range(12), $urandom_range(10), $urandom_range(5));
        random_phase(330, -1, -1);

        drain();
        repeat (4) @(posedge clk);
        errors = errors + event_q.size();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
